// ===== rtl/mac_keyed_counter_table_with_aging_core_assert.svh =====
// Assertion macros for the MAC keyed counter table.
// Expects clk and arst_n in the scope of every use.
`ifndef MAC_KEYED_COUNTER_TABLE_WITH_AGING_CORE_ASSERT_SVH
`define MAC_KEYED_COUNTER_TABLE_WITH_AGING_CORE_ASSERT_SVH

// same-cycle implication
`define MKCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MKCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mkct_pkg.sv =====
// Shared types and constants for the MAC keyed counter table.
// No dependencies.
`default_nettype none
package mkct_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam logic [15:0] TTL_RESET = 16'd30;

	// APB byte address of ttl_seconds
	localparam logic [1:0] REG_TTL_ADDR = 2'd0;

	localparam logic [2:0] OP_LOOKUP = 3'd0;
	localparam logic [2:0] OP_UPDATE = 3'd1;
	localparam logic [2:0] OP_TICK   = 3'd2;
	localparam logic [2:0] OP_FLUSH  = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	typedef struct packed {
		logic        valid;
		logic [47:0] mac;
		logic [31:0] ip;
		logic [63:0] rx;
		logic [63:0] tx;
		logic [31:0] stamp;
	} entry_t;

	typedef struct packed {
		logic        hit;
		logic        created;
		logic        table_full;
		logic [7:0]  result_slot;
		logic [47:0] entry_mac;
		logic [31:0] entry_ip;
		logic [63:0] rx_total;
		logic [63:0] tx_total;
		logic [8:0]  evicted_count;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/mac_keyed_counter_table_with_aging_core.sv =====
// MAC keyed client table with byte accounting and aging: top level.
// Depends on mkct_pkg, mkct_entry_ram and the assertion macro header.
//
// Issue a command by raising start while busy is low; the transaction is taken at that
// edge. One result follows per command, shown for exactly one cycle with done high; the
// receiver cannot stall it, so sample it then. Lookup, tick and flush walk the entry
// memory one slot per cycle through its single read port: busy stays high for the whole
// walk and done rises in the cycle after. Update and read touch one slot. A lookup hit
// reports the lowest matching slot; a miss with create_if_absent claims the lowest free
// slot. After reset the block sweeps the memory to clear every entry, holding busy high
// while it runs; APB writes are taken throughout. Write ttl_seconds only while idle; a
// zero write is ignored.
`default_nettype none
module mac_keyed_counter_table_with_aging_core #(
	parameter int TABLE_ENTRIES = mkct_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  op,
	input  wire logic [47:0] mac_addr,
	input  wire logic        create_if_absent,
	input  wire logic [7:0]  slot_index,
	input  wire logic [31:0] ipv4_addr,
	input  wire logic [31:0] rx_bytes,
	input  wire logic [31:0] tx_bytes,
	// result channel
	output logic             done,
	output logic             hit,
	output logic             created,
	output logic             table_full,
	output logic [7:0]       result_slot,
	output logic [47:0]      entry_mac,
	output logic [31:0]      entry_ip,
	output logic [63:0]      rx_total,
	output logic [63:0]      tx_total,
	output logic [8:0]       evicted_count,
	// APB config
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

`include "mac_keyed_counter_table_with_aging_core_assert.svh"

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int IW1   = IDX_W + 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W:0] LAST = IW1'(TABLE_ENTRIES);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_SLOT  = 2'd3;

	logic [1:0]  state_q;
	logic [IDX_W:0] issue_q;
	logic        vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0] now_q;
	logic [15:0] ttl_q;

	// latched command
	logic [2:0]  op_q;
	logic [47:0] mac_q;
	logic        create_q;
	logic [IDX_W-1:0] slot_q;
	logic [31:0] ip_q;
	logic [31:0] rx_q;
	logic [31:0] tx_q;

	// lookup tracking
	logic        match_q;
	logic [IDX_W-1:0] match_idx_q;
	mkct_pkg::entry_t match_ent_q;
	logic        free_q;
	logic [IDX_W-1:0] free_idx_q;

	logic        done_q;
	mkct_pkg::result_t res_q;

	// memory ports
	logic        we;
	logic [IDX_W-1:0] waddr;
	mkct_pkg::entry_t wdata;
	logic [IDX_W-1:0] raddr;
	mkct_pkg::entry_t rdata;

	logic        accept;
	logic        slot_ok;
	logic        scan_end;
	logic        evict;
	logic [31:0] life;
	logic        alive;
	logic        fire;
	mkct_pkg::result_t res_n;
	mkct_pkg::entry_t  upd;

	assign accept   = start && (state_q == ST_IDLE);
	assign slot_ok  = 32'(slot_index) < 32'(TABLE_ENTRIES);
	assign scan_end = (state_q == ST_SCAN) && (issue_q == LAST) && !vld_s1;

	// wrap-aware aging: survives when stamp + ttl - now lies in 1 .. 2^31-1
	assign life  = rdata.stamp + 32'(ttl_q) - now_q;
	assign alive = (life != 32'd0) && !life[31];
	assign evict = (state_q == ST_SCAN) && vld_s1 && rdata.valid &&
		((op_q == mkct_pkg::OP_FLUSH) || ((op_q == mkct_pkg::OP_TICK) && !alive));

	always_comb begin
		upd       = rdata;
		upd.ip    = ip_q;
		upd.rx    = rdata.rx + 64'(rx_q);
		upd.tx    = rdata.tx + 64'(tx_q);
		upd.stamp = now_q;
	end

	assign raddr = (state_q == ST_IDLE) ? IDX_W'(slot_index) : issue_q[IDX_W-1:0];

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = issue_q[IDX_W-1:0];
				wdata = '0;
			end
			ST_SCAN: begin
				if (evict) begin
					we          = 1'b1;
					wdata.valid = 1'b0;
				end else if (scan_end && (op_q == mkct_pkg::OP_LOOKUP) && !match_q &&
						create_q && free_q) begin
					we          = 1'b1;
					waddr       = free_idx_q;
					wdata       = '0;
					wdata.valid = 1'b1;
					wdata.mac   = mac_q;
					wdata.stamp = now_q;
				end
			end
			ST_SLOT: begin
				if ((op_q == mkct_pkg::OP_UPDATE) && rdata.valid) begin
					we    = 1'b1;
					waddr = slot_q;
					wdata = upd;
				end
			end
			default: ;
		endcase
	end

	// result build
	always_comb begin
		fire  = 1'b0;
		res_n = '0;
		unique case (state_q)
			ST_IDLE: begin
				// out-of-range slot or unknown op answers at once with zeros
				fire = accept && !(((op == mkct_pkg::OP_UPDATE) || (op == mkct_pkg::OP_READ)) &&
					slot_ok) && (op != mkct_pkg::OP_LOOKUP) && (op != mkct_pkg::OP_TICK) &&
					(op != mkct_pkg::OP_FLUSH);
			end
			ST_SCAN: begin
				if (scan_end) begin
					fire = 1'b1;
					if (op_q == mkct_pkg::OP_LOOKUP) begin
						if (match_q) begin
							res_n.hit         = 1'b1;
							res_n.result_slot = 8'(match_idx_q);
							res_n.entry_mac   = match_ent_q.mac;
							res_n.entry_ip    = match_ent_q.ip;
							res_n.rx_total    = match_ent_q.rx;
							res_n.tx_total    = match_ent_q.tx;
						end else if (create_q && free_q) begin
							res_n.created     = 1'b1;
							res_n.result_slot = 8'(free_idx_q);
							res_n.entry_mac   = mac_q;
						end else if (create_q) begin
							res_n.table_full  = 1'b1;
						end
					end else begin
						res_n.evicted_count = 9'(cnt_q);
					end
				end
			end
			ST_SLOT: begin
				fire = 1'b1;
				if (rdata.valid) begin
					res_n.hit         = 1'b1;
					res_n.result_slot = 8'(slot_q);
					res_n.entry_mac   = rdata.mac;
					if (op_q == mkct_pkg::OP_UPDATE) begin
						res_n.entry_ip = upd.ip;
						res_n.rx_total = upd.rx;
						res_n.tx_total = upd.tx;
					end else begin
						res_n.entry_ip = rdata.ip;
						res_n.rx_total = rdata.rx;
						res_n.tx_total = rdata.tx;
					end
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			issue_q <= '0;
			vld_s1  <= 1'b0;
			cnt_q   <= '0;
			now_q   <= '0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			done_q  <= 1'b0;
			op_q    <= mkct_pkg::OP_LOOKUP;
		end else begin
			done_q <= fire;
			unique case (state_q)
				ST_CLEAR: begin
					if (issue_q == LAST - IW1'(1)) begin
						state_q <= ST_IDLE;
					end
					issue_q <= issue_q + IW1'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						op_q    <= op;
						issue_q <= '0;
						vld_s1  <= 1'b0;
						cnt_q   <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						if (op == mkct_pkg::OP_TICK) begin
							now_q <= now_q + 32'd1;
						end
						if ((op == mkct_pkg::OP_LOOKUP) || (op == mkct_pkg::OP_TICK) ||
								(op == mkct_pkg::OP_FLUSH)) begin
							state_q <= ST_SCAN;
						end else if (((op == mkct_pkg::OP_UPDATE) ||
								(op == mkct_pkg::OP_READ)) && slot_ok) begin
							state_q <= ST_SLOT;
						end
					end
				end
				ST_SCAN: begin
					vld_s1 <= (issue_q != LAST);
					idx_s1 <= issue_q[IDX_W-1:0];
					if (issue_q != LAST) begin
						issue_q <= issue_q + IW1'(1);
					end
					if (evict) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (vld_s1 && (op_q == mkct_pkg::OP_LOOKUP)) begin
						if (rdata.valid && (rdata.mac == mac_q) && !match_q) begin
							match_q     <= 1'b1;
							match_idx_q <= idx_s1;
							match_ent_q <= rdata;
						end
						if (!rdata.valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
					if (scan_end) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SLOT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command payload and result capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mac_q    <= mac_addr;
			create_q <= create_if_absent;
			slot_q   <= IDX_W'(slot_index);
			ip_q     <= ipv4_addr;
			rx_q     <= rx_bytes;
			tx_q     <= tx_bytes;
		end
		if (fire) begin
			res_q <= res_n;
		end
	end

	// APB register: ttl_seconds, zero writes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= mkct_pkg::TTL_RESET;
		end else if (psel && penable && pwrite && pready &&
				(paddr == mkct_pkg::REG_TTL_ADDR) && (pwdata[15:0] != 16'd0)) begin
			ttl_q <= pwdata[15:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = {16'd0, ttl_q};

	mkct_entry_ram #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign hit           = res_q.hit;
	assign created       = res_q.created;
	assign table_full    = res_q.table_full;
	assign result_slot   = res_q.result_slot;
	assign entry_mac     = res_q.entry_mac;
	assign entry_ip      = res_q.entry_ip;
	assign rx_total      = res_q.rx_total;
	assign tx_total      = res_q.tx_total;
	assign evicted_count = res_q.evicted_count;

	`MKCT_ASSERT_NXT(a_accept_busy, start && !busy && (op == mkct_pkg::OP_LOOKUP), busy,
		"lookup transaction did not start a scan")
	`MKCT_ASSERT_IMP(a_done_exclusive, done, !(hit && created) && !(hit && table_full),
		"result flags conflict")
	`MKCT_ASSERT_IMP(a_full_clean, done && table_full, (result_slot == 8'd0) && !created,
		"table full result carries slot data")
	`MKCT_ASSERT_IMP(a_scan_bound, state_q == ST_SCAN, issue_q <= LAST,
		"scan counter ran past the table")

endmodule
`default_nettype wire

// ===== rtl/mkct_entry_ram.sv =====
// Entry store: one write port, one registered read port.
// Depends on mkct_pkg (entry_t).
`default_nettype none
module mkct_entry_ram #(
	parameter int DEPTH = mkct_pkg::TABLE_ENTRIES_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire mkct_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output mkct_pkg::entry_t     rdata
);

	mkct_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for mac_keyed_counter_table_with_aging_core.
// Depends on mkct_pkg and the core RTL; carries its own table predictor.
// Directed, TTL, table-full and random traffic run with varied sender idling.
`default_nettype none
module tb;

	localparam int ENTRIES = mkct_pkg::TABLE_ENTRIES_DEF;
	localparam logic [2:0] OP_BAD5 = 3'd5;
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [47:0] mac;
		logic        create;
		logic [7:0]  slot;
		logic [31:0] ip;
		logic [31:0] rx;
		logic [31:0] tx;
	} cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  op = '0;
	logic [47:0] mac_addr = '0;
	logic        create_if_absent = 1'b0;
	logic [7:0]  slot_index = '0;
	logic [31:0] ipv4_addr = '0;
	logic [31:0] rx_bytes = '0;
	logic [31:0] tx_bytes = '0;
	logic        done;
	logic        hit;
	logic        created;
	logic        table_full;
	logic [7:0]  result_slot;
	logic [47:0] entry_mac;
	logic [31:0] entry_ip;
	logic [63:0] rx_total;
	logic [63:0] tx_total;
	logic [8:0]  evicted_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	mac_keyed_counter_table_with_aging_core dut (.*);

	// 10 time unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the table
	bit          slot_live[ENTRIES];
	bit [47:0]   slot_mac[ENTRIES];
	bit [31:0]   slot_ip[ENTRIES];
	bit [63:0]   slot_rx[ENTRIES];
	bit [63:0]   slot_tx[ENTRIES];
	bit [31:0]   slot_stamp[ENTRIES];
	bit [31:0]   now_sec;
	bit [15:0]   ttl_cur = mkct_pkg::TTL_RESET;

	mkct_pkg::result_t pending_q[$];
	int          errors = 0;
	int          n_sent = 0;
	int          n_hits = 0;
	int          n_created = 0;
	int          n_full = 0;
	int          n_evicted = 0;
	int          gap_pct = 0;
	bit [47:0]   mac_pool[16];

	function automatic void show_slot(inout mkct_pkg::result_t r, input int i);
		r.result_slot = i[7:0];
		r.entry_mac   = slot_mac[i];
		r.entry_ip    = slot_ip[i];
		r.rx_total    = slot_rx[i];
		r.tx_total    = slot_tx[i];
	endfunction

	// applies one command to the table copy, returns the expected result
	function automatic mkct_pkg::result_t table_apply(cmd_t c);
		mkct_pkg::result_t r;
		bit [31:0] d;
		int cnt;
		r = '0;
		cnt = 0;
		case (c.op)
			mkct_pkg::OP_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_live[i] && slot_mac[i] == c.mac) begin
						r.hit = 1'b1;
						show_slot(r, i);
						return r;
					end
				if (!c.create)
					return r;
				for (int i = 0; i < ENTRIES; i++)
					if (!slot_live[i]) begin
						slot_live[i]  = 1'b1;
						slot_mac[i]   = c.mac;
						slot_ip[i]    = '0;
						slot_rx[i]    = '0;
						slot_tx[i]    = '0;
						slot_stamp[i] = now_sec;
						r.created = 1'b1;
						show_slot(r, i);
						return r;
					end
				r.table_full = 1'b1;
			end
			mkct_pkg::OP_UPDATE: begin
				if (slot_live[c.slot]) begin
					slot_ip[c.slot]    = c.ip;
					slot_rx[c.slot]    = slot_rx[c.slot] + 64'(c.rx);
					slot_tx[c.slot]    = slot_tx[c.slot] + 64'(c.tx);
					slot_stamp[c.slot] = now_sec;
					r.hit = 1'b1;
					show_slot(r, c.slot);
				end
			end
			mkct_pkg::OP_TICK: begin
				now_sec = now_sec + 32'd1;
				for (int i = 0; i < ENTRIES; i++) begin
					d = slot_stamp[i] + {16'b0, ttl_cur} - now_sec;
					if (slot_live[i] && !(d != 0 && d < 32'h8000_0000)) begin
						slot_live[i] = 1'b0;
						cnt++;
					end
				end
				r.evicted_count = cnt[8:0];
			end
			mkct_pkg::OP_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot_live[i]) begin
						slot_live[i] = 1'b0;
						cnt++;
					end
				r.evicted_count = cnt[8:0];
			end
			mkct_pkg::OP_READ: begin
				if (slot_live[c.slot]) begin
					r.hit = 1'b1;
					show_slot(r, c.slot);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		if (errors <= 40)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// one transaction: hold start until taken at an edge with busy low
	task automatic send(cmd_t c);
		start <= 1'b1;
		op <= c.op;
		mac_addr <= c.mac;
		create_if_absent <= c.create;
		slot_index <= c.slot;
		ipv4_addr <= c.ip;
		rx_bytes <= c.rx;
		tx_bytes <= c.tx;
		do @(posedge clk); while (busy);
		pending_q.push_back(table_apply(c));
		n_sent++;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	endtask

	function automatic cmd_t mk(logic [2:0] o, logic [47:0] m, logic cr, logic [7:0] s);
		cmd_t c;
		c.op = o;
		c.mac = m;
		c.create = cr;
		c.slot = s;
		c.ip = $urandom;
		c.rx = $urandom;
		c.tx = $urandom;
		return c;
	endfunction

	// drain results, then let a full scan pass so the core is idle
	task automatic settle();
		start <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
	endtask

	task automatic write_ttl(logic [31:0] v);
		settle();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= mkct_pkg::REG_TTL_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (v[15:0] != 0)
			ttl_cur = v[15:0];
	endtask

	function automatic logic [7:0] pick_slot();
		logic [7:0] s;
		s = '0;
		for (int k = 0; k < 12; k++) begin
			s = 8'($urandom_range(ENTRIES - 1));
			if (slot_live[s])
				return s;
		end
		return s;
	endfunction

	function automatic cmd_t rand_cmd();
		int p;
		logic [47:0] m;
		p = $urandom_range(99);
		m = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) : mac_pool[$urandom_range(15)];
		if (p < 36)
			return mk(mkct_pkg::OP_LOOKUP, m, $urandom_range(9) < 7, 8'($urandom));
		if (p < 62)
			return mk(mkct_pkg::OP_UPDATE, m, 1'($urandom),
				$urandom_range(9) < 8 ? pick_slot() : 8'($urandom));
		if (p < 76)
			return mk(mkct_pkg::OP_TICK, m, 1'($urandom), 8'($urandom));
		if (p < 78)
			return mk(mkct_pkg::OP_FLUSH, m, 1'($urandom), 8'($urandom));
		if (p < 96)
			return mk(mkct_pkg::OP_READ, m, 1'($urandom),
				$urandom_range(9) < 8 ? pick_slot() : 8'($urandom));
		return mk(3'($urandom_range(5, 7)), m, 1'($urandom), 8'($urandom));
	endfunction

	// result checker: every done cycle is matched against the oldest expectation
	always @(posedge clk) begin : check_results
		mkct_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_q.size() == 0)
				report("result with nothing pending", 0, 0);
			else begin
				want = pending_q.pop_front();
				if (hit !== want.hit) report("hit", hit, want.hit);
				if (created !== want.created) report("created", created, want.created);
				if (table_full !== want.table_full)
					report("table_full", table_full, want.table_full);
				if (result_slot !== want.result_slot)
					report("result_slot", result_slot, want.result_slot);
				if (entry_mac !== want.entry_mac) report("entry_mac", entry_mac, want.entry_mac);
				if (entry_ip !== want.entry_ip) report("entry_ip", entry_ip, want.entry_ip);
				if (rx_total !== want.rx_total) report("rx_total", rx_total, want.rx_total);
				if (tx_total !== want.tx_total) report("tx_total", tx_total, want.tx_total);
				if (evicted_count !== want.evicted_count)
					report("evicted_count", evicted_count, want.evicted_count);
				n_hits += want.hit;
				n_created += want.created;
				n_full += want.table_full;
				n_evicted += want.evicted_count;
			end
		end
	end

	// every op at least once, field extremes, empty slots and unknown ops
	task automatic test_basic_ops();
		cmd_t c;
		send(mk(mkct_pkg::OP_LOOKUP, 48'h0, 1'b0, 8'h00));       // miss without create
		send(mk(mkct_pkg::OP_LOOKUP, 48'h0, 1'b1, 8'hFF));       // create in slot 0
		send(mk(mkct_pkg::OP_LOOKUP, '1, 1'b1, 8'h00));          // create in slot 1
		send(mk(mkct_pkg::OP_LOOKUP, 48'h0, 1'b1, 8'h00));       // hit, no second claim
		c = mk(mkct_pkg::OP_UPDATE, 48'h0, 1'b0, 8'h00);
		c.ip = '1; c.rx = '1; c.tx = '1;
		send(c);
		send(c);                                       // counters carry past 32 bits
		c.slot = 8'h01; c.ip = '0; c.rx = '0; c.tx = '0;
		send(c);
		send(mk(mkct_pkg::OP_UPDATE, '1, 1'b1, 8'hFF));          // empty slot, ignored
		send(mk(mkct_pkg::OP_READ, 48'h0, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_READ, 48'h0, 1'b0, 8'h01));
		send(mk(mkct_pkg::OP_READ, 48'h0, 1'b0, 8'hFF));         // read of an empty slot
		send(mk(OP_BAD5, '1, 1'b1, 8'h00));
		send(mk(OP_BAD6, '1, 1'b1, 8'h01));
		send(mk(OP_BAD7, '1, 1'b1, 8'hFF));
		send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_LOOKUP, '1, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_FLUSH, 48'h0, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_READ, 48'h0, 1'b0, 8'h00));         // gone after flush
		send(mk(mkct_pkg::OP_FLUSH, 48'h0, 1'b0, 8'h00));        // empty flush
	endtask

	// eviction edges at the smallest TTLs, zero-write ignored, largest TTL
	task automatic test_ttl_aging();
		write_ttl(32'h0000_0001);
		send(mk(mkct_pkg::OP_LOOKUP, 48'h1234_5678_9ABC, 1'b1, 8'h00));
		send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));         // stamp+ttl == now: evicted
		write_ttl(32'hFFFF_0002);
		send(mk(mkct_pkg::OP_LOOKUP, 48'h1234_5678_9ABC, 1'b1, 8'h00));
		send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));         // one second left: survives
		send(mk(mkct_pkg::OP_UPDATE, 48'h0, 1'b0, 8'h00));       // refresh stamp
		send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));
		write_ttl(32'h0000_0000);                      // ignored, stays 2
		send(mk(mkct_pkg::OP_LOOKUP, 48'h1, 1'b1, 8'h00));
		send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));
		write_ttl(32'h0000_FFFF);
		send(mk(mkct_pkg::OP_LOOKUP, 48'h2, 1'b1, 8'h00));
		repeat (3) send(mk(mkct_pkg::OP_TICK, 48'h0, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_FLUSH, 48'h0, 1'b0, 8'h00));
	endtask

	// fill every slot, then one more create reports full
	task automatic test_table_full();
		for (int i = 0; i < ENTRIES; i++)
			send(mk(mkct_pkg::OP_LOOKUP, {16'($urandom_range(65535)), 24'h0, i[7:0]}, 1'b1,
				8'h00));
		send(mk(mkct_pkg::OP_LOOKUP, '1, 1'b1, 8'h00));
		send(mk(mkct_pkg::OP_LOOKUP, '1, 1'b0, 8'h00));
		send(mk(mkct_pkg::OP_READ, 48'h0, 1'b0, 8'hFF));
		send(mk(mkct_pkg::OP_FLUSH, 48'h0, 1'b0, 8'h00));        // evicts all 256
	endtask

	task automatic test_random(int items, int pct, logic [31:0] ttl);
		write_ttl(ttl);
		gap_pct = pct;
		repeat (items) send(rand_cmd());
		gap_pct = 0;
	endtask

	initial begin
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			mac_pool[i] = 48'({$urandom, $urandom});
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_ttl_aging();
		test_table_full();
		test_random(300, 0, 32'd3);
		test_random(300, 68, 32'h0001_FFFF);
		test_random(300, 0, 32'd30);
		test_random(300, 21, 32'd8);
		settle();
		$display("covered %0d commands: %0d hits, %0d creates, %0d table-full, %0d evictions",
			n_sent, n_hits, n_created, n_full, n_evicted);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
